### rtl/jdc_pkg.sv
`default_nettype none

package jdc_pkg;

  // conditioning constants
  localparam int CAL_SAMPLES = 5;
  localparam int DEAD_ZONE   = 200;
  localparam int FULL_SCALE  = 2000;
  localparam int OUT_SCALE   = 100;

  // field widths
  localparam int SAMPLE_W    = 12;
  localparam int POS_OUT_W   = 8;
  localparam int FLAGS_W     = 4;
  localparam int THR_W       = 7;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);

  // direction flag bits
  localparam int FLAG_X_POS  = 0;
  localparam int FLAG_X_NEG  = 1;
  localparam int FLAG_Y_POS  = 2;
  localparam int FLAG_Y_NEG  = 3;

  // calibration accumulator
  localparam int CNT_W       = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W       = $clog2(CAL_SAMPLES * (2 ** (SAMPLE_W - 1))) + 1;
  localparam int DIV_SHIFT   = 20;
  localparam longint DIV_RECIP = ((longint'(1) << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int DIV_RECIP_W = $clog2(DIV_RECIP + 1);
  localparam int DIV_PROD_W  = SUM_W + DIV_RECIP_W;

  // axis datapath
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int V_W         = SAMPLE_W + 2;
  localparam int SAT         = (FULL_SCALE < 4096) ? FULL_SCALE : 4096;
  localparam int SPAN        = FULL_SCALE - DEAD_ZONE;
  localparam int SPAN_SAFE   = (SPAN > 0) ? SPAN : 1;
  localparam int MAP_D_W     = $clog2(SPAN_SAFE + 1);
  localparam int MAP_SHIFT   = 2 * MAP_D_W;
  localparam longint MAP_MULT =
    ((longint'(OUT_SCALE) << MAP_SHIFT) + SPAN_SAFE - 1) / SPAN_SAFE;
  localparam int MAP_MULT_W  = $clog2(MAP_MULT + 1);
  localparam int MAP_PROD_W  = MAP_D_W + MAP_MULT_W;
  localparam int Q_W         = $clog2(OUT_SCALE + 1);
  localparam int POS_W       = Q_W + 1;

  // average of the calibration sum, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] cal_average(
    input logic signed [SUM_W-1:0] sum
  );
    logic [SUM_W-1:0]      mag;
    logic [DIV_PROD_W-1:0] prod;
    logic [SAMPLE_W-1:0]   quo;
    mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    prod = DIV_PROD_W'(mag) * DIV_PROD_W'(DIV_RECIP);
    quo  = SAMPLE_W'(prod >> DIV_SHIFT);
    return sum[SUM_W-1] ? $signed(SAMPLE_W'(-quo)) : $signed(quo);
  endfunction

  // position narrowed to the output field
  function automatic logic [POS_OUT_W-1:0] pos_to_port(input logic signed [POS_W-1:0] pos);
    logic signed [31:0] wide;
    wide = 32'(pos);
    return wide[POS_OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/jdc_axis.sv
`default_nettype none

module jdc_axis
  import jdc_pkg::*;
(
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic signed [SAMPLE_W-1:0] offset_i,
  output logic signed [POS_W-1:0]         pos_o
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [V_W-1:0]    sat;
  logic signed [V_W-1:0]    neg;
  logic signed [31:0]       live_dist;
  logic [MAP_D_W-1:0]       d;
  logic [MAP_PROD_W-1:0]    prod;
  logic [Q_W-1:0]           q;

  always_comb begin
    diff = DIFF_W'(sample_i) - DIFF_W'(offset_i);
    if (diff > SAT) begin
      sat = V_W'(SAT);
    end else if (diff < -SAT) begin
      sat = V_W'(-SAT);
    end else begin
      sat = V_W'(diff);
    end
    neg = -sat;

    // distance into the live range of the active side
    if (neg > 0) begin
      live_dist = (neg < DEAD_ZONE) ? 32'sd0 : (32'(neg) - DEAD_ZONE);
    end else begin
      live_dist = (neg > -DEAD_ZONE) ? (FULL_SCALE - DEAD_ZONE) : (32'(neg) + FULL_SCALE);
    end
    d    = MAP_D_W'(live_dist);
    prod = MAP_PROD_W'(d) * MAP_PROD_W'(MAP_MULT);
    q    = Q_W'(prod >> MAP_SHIFT);

    if (neg == 0) begin
      pos_o = '0;
    end else if (SPAN <= 0) begin
      pos_o = (neg > 0) ? POS_W'(OUT_SCALE) : POS_W'(-OUT_SCALE);
    end else if (neg > 0) begin
      pos_o = $signed({1'b0, q});
    end else begin
      pos_o = $signed({1'b0, q}) - POS_W'(OUT_SCALE);
    end
  end

endmodule

`default_nettype wire

### rtl/joystick_deadzone_conditioner_top.sv
// channel   | valid       | stall       | payload
// ----------+-------------+-------------+---------------------------------------------
// input     | in_valid_i  | in_stall_o  | action_i, x_sample_i, y_sample_i
// output    | out_valid_o | out_stall_i | x_position_o, y_position_o,
//           |             |             | direction_flags_o, calibration_done_o
// config    | cfg_we_i    | -           | cfg_wdata_i (press threshold)
//
// one transaction per cycle while the output is not stalled; a transaction passes
// through the input register and then the result register
// an input register feeds the axis mappers, the result register holds the output
// reset clears the threshold to its default, the offsets, sums and calibration count
// a stalled output holds its transaction; the input register still takes one more
// transaction and stalls only when it is full and cannot move forward

`default_nettype none

module joystick_deadzone_conditioner_top
  import jdc_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,

  input  wire logic                       cfg_we_i,
  input  wire logic [THR_W-1:0]           cfg_wdata_i,

  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       action_i,
  input  wire logic signed [SAMPLE_W-1:0] x_sample_i,
  input  wire logic signed [SAMPLE_W-1:0] y_sample_i,

  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [POS_OUT_W-1:0]            x_position_o,
  output logic [POS_OUT_W-1:0]            y_position_o,
  output logic [FLAGS_W-1:0]              direction_flags_o,
  output logic                            calibration_done_o
);

  // input register
  logic                       s1_valid_q;
  logic                       s1_action_q;
  logic signed [SAMPLE_W-1:0] s1_x_q, s1_y_q;

  // configuration and calibration state
  logic [THR_W-1:0]           thr_q;
  logic [CNT_W-1:0]           cal_count_q, cal_count_d;
  logic signed [SUM_W-1:0]    x_sum_q, x_sum_d, y_sum_q, y_sum_d;
  logic signed [SAMPLE_W-1:0] x_offset_q, x_offset_d, y_offset_q, y_offset_d;

  // result register
  logic                       out_valid_q;
  logic [POS_OUT_W-1:0]       x_pos_q, x_pos_d, y_pos_q, y_pos_d;
  logic [FLAGS_W-1:0]         flags_q, flags_d;
  logic                       done_q, done_d;

  logic                       advance;
  logic                       in_accept;
  logic [CNT_W-1:0]           cnt_inc;
  logic signed [SUM_W-1:0]    x_sum_add, y_sum_add;
  logic signed [POS_W-1:0]    x_pos, y_pos;

  // the input register moves forward when the result register is free or draining
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  jdc_axis u_axis_x (
    .sample_i (s1_x_q),
    .offset_i (x_offset_q),
    .pos_o    (x_pos)
  );

  jdc_axis u_axis_y (
    .sample_i (s1_y_q),
    .offset_i (y_offset_q),
    .pos_o    (y_pos)
  );

  always_comb begin
    cnt_inc    = cal_count_q + CNT_W'(1);
    x_sum_add  = x_sum_q + SUM_W'(s1_x_q);
    y_sum_add  = y_sum_q + SUM_W'(s1_y_q);

    cal_count_d = cal_count_q;
    x_sum_d     = x_sum_q;
    y_sum_d     = y_sum_q;
    x_offset_d  = x_offset_q;
    y_offset_d  = y_offset_q;
    x_pos_d     = '0;
    y_pos_d     = '0;
    flags_d     = '0;
    done_d      = 1'b0;

    if (s1_action_q) begin
      // calibration transaction: accumulate, and average on the last one
      if (cnt_inc >= CNT_W'(CAL_SAMPLES)) begin
        x_offset_d  = cal_average(x_sum_add);
        y_offset_d  = cal_average(y_sum_add);
        x_sum_d     = '0;
        y_sum_d     = '0;
        cal_count_d = '0;
        done_d      = 1'b1;
      end else begin
        x_sum_d     = x_sum_add;
        y_sum_d     = y_sum_add;
        cal_count_d = cnt_inc;
      end
    end else begin
      // normal transaction: flags use the full-width position, signed compare
      x_pos_d = pos_to_port(x_pos);
      y_pos_d = pos_to_port(y_pos);
      flags_d[FLAG_X_POS] = int'(x_pos) > int'(thr_q);
      flags_d[FLAG_X_NEG] = int'(x_pos) < -int'(thr_q);
      flags_d[FLAG_Y_POS] = int'(y_pos) > int'(thr_q);
      flags_d[FLAG_Y_NEG] = int'(y_pos) < -int'(thr_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= THR_RESET;
      cal_count_q <= '0;
      x_sum_q     <= '0;
      y_sum_q     <= '0;
      x_offset_q  <= '0;
      y_offset_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        cal_count_q <= cal_count_d;
        x_sum_q     <= x_sum_d;
        y_sum_q     <= y_sum_d;
        x_offset_q  <= x_offset_d;
        y_offset_q  <= y_offset_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_x_q      <= x_sample_i;
      s1_y_q      <= y_sample_i;
    end
    if (advance) begin
      x_pos_q <= x_pos_d;
      y_pos_q <= y_pos_d;
      flags_q <= flags_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign x_position_o       = x_pos_q;
  assign y_position_o       = y_pos_q;
  assign direction_flags_o  = flags_q;
  assign calibration_done_o = done_q;

  // calibration results carry no position or flags
  a_cal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calibration_done_o |->
      x_position_o == '0 && y_position_o == '0 && direction_flags_o == '0)
    else $error("calibration transaction carries position data");

  // an axis cannot be pressed both ways
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(direction_flags_o[FLAG_X_POS] && direction_flags_o[FLAG_X_NEG]) &&
                    !(direction_flags_o[FLAG_Y_POS] && direction_flags_o[FLAG_Y_NEG]))
    else $error("opposite direction flags both set");

  // calibration count wraps before reaching the sample count
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_count_q < CNT_W'(CAL_SAMPLES))
    else $error("calibration count out of range");

  // input stalls only while the input register holds a transaction
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room to move");

  // offsets change only on a completing calibration transaction
  a_offset_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s1_action_q && cnt_inc >= CNT_W'(CAL_SAMPLES)) |=>
      $stable(x_offset_q) && $stable(y_offset_q))
    else $error("offset changed outside calibration");

endmodule

`default_nettype wire

### verif/joystick_deadzone_conditioner_top_tb.sv
module joystick_deadzone_conditioner_top_tb;
  import jdc_pkg::*;

  // run shape
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PIPE_LATENCY    = 2;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_PRINTED     = 50;

  // action codes of an input transaction
  localparam logic NORMAL_SAMPLE = 1'b0;
  localparam logic CAL_SAMPLE    = 1'b1;

  // one expected output transaction
  typedef struct packed {
    logic [POS_OUT_W-1:0] x_pos;
    logic [POS_OUT_W-1:0] y_pos;
    logic [FLAGS_W-1:0]   flags;
    logic                 done;
  } position_result_t;

  // tracks calibration state and threshold, predicts positions in order
  class deadzone_scoreboard;
    int threshold;
    int cal_count;
    int x_cal_sum;
    int y_cal_sum;
    int x_offset;
    int y_offset;
    int mismatches;
    position_result_t expected_positions[$];

    function new(int thr);
      threshold  = thr;
      cal_count  = 0;
      x_cal_sum  = 0;
      y_cal_sum  = 0;
      x_offset   = 0;
      y_offset   = 0;
      mismatches = 0;
    endfunction

    function void set_threshold(int thr);
      threshold = thr;
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction

    // offset removal, saturation, inversion, dead zone and linear scaling
    function int predict_axis(int sample, int offset);
      int v;
      int span;
      span = FULL_SCALE - DEAD_ZONE;
      v = sample - offset;
      if (v > FULL_SCALE) v = FULL_SCALE;
      if (v < -FULL_SCALE) v = -FULL_SCALE;
      v = -v;
      if (v == 0) return 0;
      if (span <= 0) return (v > 0) ? OUT_SCALE : -OUT_SCALE;
      if (v > 0) begin
        if (v < DEAD_ZONE) v = DEAD_ZONE;
        return (v - DEAD_ZONE) * OUT_SCALE / span;
      end
      if (v > -DEAD_ZONE) v = -DEAD_ZONE;
      return (v + FULL_SCALE) * OUT_SCALE / span - OUT_SCALE;
    endfunction

    function void note_sample(logic act, logic signed [SAMPLE_W-1:0] xs,
                              logic signed [SAMPLE_W-1:0] ys);
      position_result_t r;
      int xp;
      int yp;
      r = '0;
      if (act == CAL_SAMPLE) begin
        x_cal_sum += int'(xs);
        y_cal_sum += int'(ys);
        cal_count++;
        if (cal_count >= CAL_SAMPLES) begin
          // integer division truncates toward zero
          x_offset  = x_cal_sum / CAL_SAMPLES;
          y_offset  = y_cal_sum / CAL_SAMPLES;
          x_cal_sum = 0;
          y_cal_sum = 0;
          cal_count = 0;
          r.done    = 1'b1;
        end
      end else begin
        xp = predict_axis(int'(xs), x_offset);
        yp = predict_axis(int'(ys), y_offset);
        r.x_pos = xp[POS_OUT_W-1:0];
        r.y_pos = yp[POS_OUT_W-1:0];
        r.flags[FLAG_X_POS] = (xp > threshold);
        r.flags[FLAG_X_NEG] = (xp < -threshold);
        r.flags[FLAG_Y_POS] = (yp > threshold);
        r.flags[FLAG_Y_NEG] = (yp < -threshold);
      end
      expected_positions.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_position(input logic [POS_OUT_W-1:0] xp, input logic [POS_OUT_W-1:0] yp,
                        input logic [FLAGS_W-1:0] fl, input logic dn);
      position_result_t want;
      if (expected_positions.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d flags=%h done=%b",
                                  $signed(xp), $signed(yp), fl, dn));
        return;
      end
      want = expected_positions.pop_front();
      if (xp !== want.x_pos)
        report_mismatch($sformatf("x_position %0d, want %0d", $signed(xp), $signed(want.x_pos)));
      if (yp !== want.y_pos)
        report_mismatch($sformatf("y_position %0d, want %0d", $signed(yp), $signed(want.y_pos)));
      if (fl !== want.flags)
        report_mismatch($sformatf("direction_flags %h, want %h", fl, want.flags));
      if (dn !== want.done)
        report_mismatch($sformatf("calibration_done %b, want %b", dn, want.done));
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [THR_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       action_i;
  logic signed [SAMPLE_W-1:0] x_sample_i;
  logic signed [SAMPLE_W-1:0] y_sample_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [POS_OUT_W-1:0]       x_position_o;
  logic [POS_OUT_W-1:0]       y_position_o;
  logic [FLAGS_W-1:0]         direction_flags_o;
  logic                       calibration_done_o;

  deadzone_scoreboard sb;

  // idling knobs, percent of cycles
  int sender_idle_pct;
  int stall_pct;
  // long receiver hold-off, counted down by the receiver process
  int hold_off_left;

  joystick_deadzone_conditioner_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .action_i           (action_i),
    .x_sample_i         (x_sample_i),
    .y_sample_i         (y_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .x_position_o       (x_position_o),
    .y_position_o       (y_position_o),
    .direction_flags_o  (direction_flags_o),
    .calibration_done_o (calibration_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // both channels are sampled at the edge, before any update of that edge lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_sample(action_i, x_sample_i, y_sample_i);
      if (out_valid_o && !out_stall_i)
        sb.check_position(x_position_o, y_position_o, direction_flags_o, calibration_done_o);
    end
  end

  // receiver: random stalls, or a long hold-off that fills the pipeline
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog: too many cycles without any transaction on either channel
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck = 0;
      else stuck++;
    end
    $display("FAIL joystick_deadzone_conditioner_top");
    $finish;
  end

  // offer one transaction and hold it until taken; gaps only before it
  task automatic send_sample(logic act, logic signed [SAMPLE_W-1:0] xs,
                             logic signed [SAMPLE_W-1:0] ys);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    x_sample_i <= xs;
    y_sample_i <= ys;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // wait for the pipeline to empty, then update the press threshold
  task automatic write_threshold(int thr);
    in_valid_i <= 1'b0;
    // let the monitor note the last accepted transaction first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= THR_W'(thr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_threshold(thr & ((1 << THR_W) - 1));
  endtask

  // mostly in-range readings, some near the dead zone, some anywhere in 12 bits
  function automatic logic signed [SAMPLE_W-1:0] random_reading();
    int kind;
    int v;
    kind = $urandom_range(9);
    case (kind)
      5:       v = int'($urandom);
      6, 7:    v = int'($urandom_range(500)) - 250;
      8: begin
        case ($urandom_range(5))
          0:       v = -2048;
          1:       v = 2047;
          2:       v = -FULL_SCALE;
          3:       v = FULL_SCALE;
          4:       v = -FULL_SCALE - 1;
          default: v = FULL_SCALE + 1;
        endcase
      end
      default: v = int'($urandom_range(2 * FULL_SCALE)) - FULL_SCALE;
    endcase
    return SAMPLE_W'(v);
  endfunction

  function automatic logic random_action();
    return ($urandom_range(99) < 25) ? CAL_SAMPLE : NORMAL_SAMPLE;
  endfunction

  initial begin
    int thr;
    sb = new(int'(THR_RESET));
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    action_i        = NORMAL_SAMPLE;
    x_sample_i      = '0;
    y_sample_i      = '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_off_left   = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero offsets, default threshold
    // zero difference, one count either side, inside and at the dead zone edge
    send_sample(NORMAL_SAMPLE, 0, 0);
    send_sample(NORMAL_SAMPLE, 1, -1);
    send_sample(NORMAL_SAMPLE, 199, -199);
    send_sample(NORMAL_SAMPLE, 200, -200);
    send_sample(NORMAL_SAMPLE, 201, -201);
    // full scale and readings beyond it that must saturate
    send_sample(NORMAL_SAMPLE, 2000, -2000);
    send_sample(NORMAL_SAMPLE, 2047, -2048);
    // exactly at the threshold versus just above it
    send_sample(NORMAL_SAMPLE, -1100, 1100);
    send_sample(NORMAL_SAMPLE, -1100, 1118);

    // calibration with negative and positive sums that need truncation
    send_sample(CAL_SAMPLE, -3, 3);
    send_sample(CAL_SAMPLE, -3, 3);
    send_sample(CAL_SAMPLE, -3, 3);
    send_sample(CAL_SAMPLE, -3, 3);
    send_sample(CAL_SAMPLE, -1, 1);
    send_sample(NORMAL_SAMPLE, -2, 2);
    send_sample(NORMAL_SAMPLE, 0, 0);

    // calibration to the most extreme offsets, then the widest differences
    repeat (CAL_SAMPLES) send_sample(CAL_SAMPLE, -2048, 2047);
    send_sample(NORMAL_SAMPLE, 2047, -2048);
    send_sample(NORMAL_SAMPLE, -2048, 2047);

    // random phases, each setting a press threshold and an idling pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       thr = 0;
        1:       thr = 100;
        2:       thr = 127;
        3:       thr = 1;
        4:       thr = 99;
        7:       thr = 50;
        default: thr = $urandom_range(100);
      endcase
      write_threshold(thr);
      case (p)
        1, 5:    begin sender_idle_pct = 70; stall_pct = 0;  end
        2, 6:    begin sender_idle_pct = 0;  stall_pct = 70; end
        3, 7:    begin sender_idle_pct = 31; stall_pct = 31; end
        default: begin sender_idle_pct = 0;  stall_pct = 0;  end
      endcase
      // back-pressure: receiver holds off while the sender keeps offering
      if (p == 4) hold_off_left = HOLD_OFF_CYCLES;
      repeat (ITEMS_PER_PHASE) send_sample(random_action(), random_reading(), random_reading());
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);

    if (sb.mismatches == 0) $display("PASS joystick_deadzone_conditioner_top");
    else $display("FAIL joystick_deadzone_conditioner_top");
    $finish;
  end

endmodule
